// ===== hdl/fcp_pkg.sv =====
package fcp_pkg;

  localparam int unsigned FRAME_LEN   = 14;
  localparam int unsigned PAYLOAD_LEN = 11;
  localparam int unsigned STORE_DEPTH = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0]  POS_FIRST   = 4'd1;
  localparam logic [3:0]  POS_PAYLOAD = 4'(PAYLOAD_LEN);
  localparam logic [3:0]  POS_STORE   = 4'(STORE_DEPTH);
  localparam logic [3:0]  POS_LAST    = 4'(FRAME_LEN - 1);

  localparam logic [11:0] SPIN_FLOOR  = 12'd50;

  localparam logic [7:0]  START_RESET = 8'd170;
  localparam logic [7:0]  END_RESET   = 8'd85;
  localparam logic [15:0] PMIN_RESET  = 16'd1000;
  localparam logic [15:0] PCAP_RESET  = 16'd2000;

  typedef enum logic [1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_END_BYTE   = 2'd1,
    CFG_PULSE_MIN  = 2'd2,
    CFG_PULSE_CAP  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ST_HUNT  = 1'b0,
    ST_FRAME = 1'b1
  } parse_state_e;

  // classified item passed from the parser to the decoder
  typedef struct packed {
    logic        good;
    logic [7:0]  mode;
    logic [15:0] pan;
    logic [15:0] tilt;
    logic        fire_nz;
    logic [15:0] idle_raw;
    logic [15:0] fire_raw;
    logic [7:0]  spin_raw;
  } cmd_t;

  // queue push side
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  // queue pop side
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } pop_t;

endpackage

// ===== hdl/fcp_front.sv =====
module fcp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       start_byte_i,
  input  logic [7:0]       end_byte_i,
  output fcp_pkg::push_t   push_o
);

  fcp_pkg::parse_state_e state_q, state_d;
  logic [3:0] pos_q, pos_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] store_q [fcp_pkg::STORE_DEPTH];
  logic       store_we;
  logic [3:0] store_idx;
  logic       last_byte;

  assign store_idx = pos_q - 4'd1;
  assign last_byte = (state_q == fcp_pkg::ST_FRAME) && (pos_q == fcp_pkg::POS_LAST);

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    xor_d    = xor_q;
    store_we = 1'b0;
    case (state_q)
      fcp_pkg::ST_HUNT: begin
        if (accept_i && (rx_byte_i == start_byte_i)) begin
          state_d = fcp_pkg::ST_FRAME;
          pos_d   = fcp_pkg::POS_FIRST;
          xor_d   = 8'd0;
        end
      end
      fcp_pkg::ST_FRAME: begin
        if (accept_i) begin
          if (pos_q <= fcp_pkg::POS_PAYLOAD) begin
            xor_d = xor_q ^ rx_byte_i;
          end
          store_we = (pos_q <= fcp_pkg::POS_STORE);
          if (last_byte) begin
            state_d = fcp_pkg::ST_HUNT;
            pos_d   = 4'd0;
          end else begin
            pos_d = pos_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = fcp_pkg::ST_HUNT;
        pos_d   = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcp_pkg::ST_HUNT;
      pos_q   <= 4'd0;
      xor_q   <= 8'd0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[store_idx] <= rx_byte_i;
    end
  end

  // every byte yields one item; only a checked last byte marks it good
  always_comb begin
    push_o.valid        = accept_i;
    push_o.cmd.good     = last_byte && (rx_byte_i == end_byte_i)
                          && (xor_q == store_q[fcp_pkg::STORE_DEPTH-1]);
    push_o.cmd.mode     = store_q[0];
    push_o.cmd.pan      = {store_q[1], store_q[2]};
    push_o.cmd.tilt     = {store_q[3], store_q[4]};
    push_o.cmd.fire_nz  = (store_q[5] != 8'd0);
    push_o.cmd.idle_raw = {store_q[6], store_q[7]};
    push_o.cmd.fire_raw = {store_q[8], store_q[9]};
    push_o.cmd.spin_raw = store_q[10];
  end

endmodule

// ===== hdl/fcp_queue.sv =====
module fcp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fcp_pkg::push_t push_i,
  output logic           full_o,
  input  logic           pop_i,
  output fcp_pkg::pop_t  pop_o
);

  fcp_pkg::cmd_t mem_q [fcp_pkg::QUEUE_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'(fcp_pkg::QUEUE_DEPTH));
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (count_q != 2'd0);

  assign pop_o.valid = (count_q != 2'd0);
  assign pop_o.cmd   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

// ===== hdl/fcp_back.sv =====
module fcp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcp_pkg::pop_t      pop_i,
  output logic               pop_o,
  input  logic [15:0]        pulse_min_i,
  input  logic [15:0]        pulse_cap_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               frame_done_o,
  output logic [7:0]         mode_value_o,
  output logic signed [15:0] pan_value_o,
  output logic signed [15:0] tilt_value_o,
  output logic               fire_flag_o,
  output logic [15:0]        idle_pulse_us_o,
  output logic [15:0]        fire_pulse_us_o,
  output logic [11:0]        spin_time_ms_o
);

  logic        valid_q;
  logic        load;
  logic [15:0] idle_c, fire_c, fire_r;
  logic [11:0] spin_x10, spin_f;
  logic        good;

  assign load  = pop_i.valid && (!valid_q || !out_stall_i);
  assign pop_o = load;
  assign good  = pop_i.cmd.good;

  // min is checked first, so with crossed bounds a value below the minimum gets the minimum and any other the cap
  assign idle_c = (pop_i.cmd.idle_raw < pulse_min_i) ? pulse_min_i :
                  (pop_i.cmd.idle_raw > pulse_cap_i) ? pulse_cap_i : pop_i.cmd.idle_raw;
  assign fire_c = (pop_i.cmd.fire_raw < pulse_min_i) ? pulse_min_i :
                  (pop_i.cmd.fire_raw > pulse_cap_i) ? pulse_cap_i : pop_i.cmd.fire_raw;
  assign fire_r = (fire_c < idle_c) ? idle_c : fire_c;

  // times ten as x8 + x2
  assign spin_x10 = {1'b0, pop_i.cmd.spin_raw, 3'b000} + {3'b000, pop_i.cmd.spin_raw, 1'b0};
  assign spin_f   = (spin_x10 < fcp_pkg::SPIN_FLOOR) ? fcp_pkg::SPIN_FLOOR : spin_x10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_done_o    <= good;
      mode_value_o    <= good ? pop_i.cmd.mode : 8'd0;
      pan_value_o     <= good ? pop_i.cmd.pan : 16'sd0;
      tilt_value_o    <= good ? pop_i.cmd.tilt : 16'sd0;
      fire_flag_o     <= good && pop_i.cmd.fire_nz;
      idle_pulse_us_o <= good ? idle_c : 16'd0;
      fire_pulse_us_o <= good ? fire_r : 16'd0;
      spin_time_ms_o  <= good ? spin_f : 12'd0;
    end
  end

  assign out_valid_o = valid_q;

endmodule

// ===== hdl/framed_command_parser_core.sv =====
// channel   | valid / stall             | payload
// ----------+---------------------------+---------------------------------------------
// input     | in_valid_i / in_stall_o   | rx_byte_i
// output    | out_valid_o / out_stall_i | frame_done_o, mode_value_o, pan_value_o,
//           |                           | tilt_value_o, fire_flag_o, idle_pulse_us_o,
//           |                           | fire_pulse_us_o, spin_time_ms_o
// config    | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// one byte transfer per cycle sustained unless the output stalls; every byte gives
// exactly one result transfer; the parser pushes each byte's item into the queue at
// the transfer edge, and the decoder loads it from there into the output register
// the parser state, queue and output valid clear on reset; config resets to its defaults
// in_stall_o rises only when the two-entry queue is full, as output stalls back up
// into it; the frame store is not reset
module framed_command_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  // config writes
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  // decoded result
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               frame_done_o,
  output logic [7:0]         mode_value_o,
  output logic signed [15:0] pan_value_o,
  output logic signed [15:0] tilt_value_o,
  output logic               fire_flag_o,
  output logic [15:0]        idle_pulse_us_o,
  output logic [15:0]        fire_pulse_us_o,
  output logic [11:0]        spin_time_ms_o
);

  // config registers
  logic [7:0]  start_byte_q;
  logic [7:0]  end_byte_q;
  logic [15:0] pulse_min_q;
  logic [15:0] pulse_cap_q;

  fcp_pkg::push_t push;
  fcp_pkg::pop_t  pop_data;
  logic           q_full;
  logic           pop_req;
  logic           in_accept;

  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  // writes by index; user changes config only while the block is idle (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= fcp_pkg::START_RESET;
      end_byte_q   <= fcp_pkg::END_RESET;
      pulse_min_q  <= fcp_pkg::PMIN_RESET;
      pulse_cap_q  <= fcp_pkg::PCAP_RESET;
    end else if (cfg_we_i) begin
      case (fcp_pkg::cfg_idx_e'(cfg_idx_i))
        fcp_pkg::CFG_START_BYTE: start_byte_q <= cfg_data_i[7:0];
        fcp_pkg::CFG_END_BYTE:   end_byte_q   <= cfg_data_i[7:0];
        fcp_pkg::CFG_PULSE_MIN:  pulse_min_q  <= cfg_data_i;
        fcp_pkg::CFG_PULSE_CAP:  pulse_cap_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: hunt for start byte, track position and checksum, classify each byte
  fcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .rx_byte_i    (rx_byte_i),
    .start_byte_i (start_byte_q),
    .end_byte_i   (end_byte_q),
    .push_o       (push)
  );

  // short queue so the parser and decoder stall on their own
  fcp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop_req),
    .pop_o  (pop_data)
  );

  // back: clamp pulses, scale spin time, zero fields of non-frame results
  fcp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_i           (pop_data),
    .pop_o           (pop_req),
    .pulse_min_i     (pulse_min_q),
    .pulse_cap_i     (pulse_cap_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_done_o    (frame_done_o),
    .mode_value_o    (mode_value_o),
    .pan_value_o     (pan_value_o),
    .tilt_value_o    (tilt_value_o),
    .fire_flag_o     (fire_flag_o),
    .idle_pulse_us_o (idle_pulse_us_o),
    .fire_pulse_us_o (fire_pulse_us_o),
    .spin_time_ms_o  (spin_time_ms_o)
  );

  // results that are not frames carry all-zero fields
  a_no_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |->
      mode_value_o == 8'd0 && pan_value_o == 16'sd0 && tilt_value_o == 16'sd0 &&
      !fire_flag_o && idle_pulse_us_o == 16'd0 && fire_pulse_us_o == 16'd0 &&
      spin_time_ms_o == 12'd0)
    else $error("non-frame result has nonzero fields");

  // fire pulse is never below idle pulse on a reported frame
  a_fire_ge_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> fire_pulse_us_o >= idle_pulse_us_o)
    else $error("fire pulse below idle pulse");

  // spin time respects its floor on a reported frame
  a_spin_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> spin_time_ms_o >= fcp_pkg::SPIN_FLOOR)
    else $error("spin time below floor");

  // a stalled result stays put while the queue keeps filling behind it
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_done_o))
    else $error("stalled result changed");

endmodule
